[design/fir_lowpass_49_tap_assert.svh]
// Assertion macros for the port-level checker of the low-pass filter.
`ifndef FIR_LOWPASS_49_TAP_ASSERT_SVH
`define FIR_LOWPASS_49_TAP_ASSERT_SVH

// Checked at every clock edge outside reset.
`define FIR_LP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define FIR_LP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/fir_lp_pkg.sv]
// Shared constants, types and the coefficient table of the low-pass filter.
`timescale 1ns / 1ps
`default_nettype none

package fir_lp_pkg;

  localparam int TAPS           = 50;
  localparam int SAMPLE_BITS    = 13;
  localparam int COEF_FRAC_BITS = 15;
  localparam int OUT_BITS       = 30;
  localparam int COEF_TABLE_LEN = 49;

  // Every coefficient is below one in magnitude, so one sign bit suffices.
  localparam int COEF_W = COEF_FRAC_BITS + 1;
  localparam int PROD_W = SAMPLE_BITS + COEF_W;
  localparam int SLOT_W = $clog2(TAPS);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [OUT_BITS-1:0]    acc_t;
  typedef logic [SLOT_W-1:0]             slot_t;

  typedef int    coef_e4_arr_t [COEF_TABLE_LEN];
  typedef coef_t coef_arr_t    [TAPS];

  // Low-pass set in units of 1e-4; the first entry weights the newest sample.
  localparam coef_e4_arr_t COEF_E4 = '{
      46,    74,   -24,   -71,    33,     1,   -94,    40,    44,
    -133,    30,   114,  -179,   -11,   223,  -225,  -109,   396,
    -263,  -338,   752,  -289, -1204,  2879,  6369,  2879, -1204,
    -289,   752,  -338,  -263,   396,  -109,  -225,   223,   -11,
    -179,   114,    30,  -133,    44,    40,   -94,     1,    33,
     -71,   -24,    74,    46
  };

  // Rounds each entry to COEF_FRAC_BITS fractional bits, halves away from zero.
  // Taps beyond the table get zero. Evaluated at elaboration only.
  function automatic coef_arr_t build_coefs();
    coef_arr_t r;
    longint    c;
    longint    mag;
    longint    q;
    for (int i = 0; i < TAPS; i++) begin
      c = (i < COEF_TABLE_LEN) ? longint'(COEF_E4[i]) : 64'sd0;
      mag = (c < 0) ? -c : c;
      q = (mag * (longint'(1) << COEF_FRAC_BITS) + 5000) / 10000;
      r[i] = COEF_W'((c < 0) ? -q : q);
    end
    return r;
  endfunction

  localparam coef_arr_t COEF_Q = build_coefs();

  // Tap control travelling alongside the delay-line read data.
  typedef struct packed {
    logic  vld;    // a tap read is in flight
    logic  first;  // newest sample, restarts the sum
    logic  last;   // oldest sample, completes the sum
    logic  live;   // the entry has been written since reset
    slot_t tap;    // coefficient index
  } tap_ctl_t;

endpackage

`default_nettype wire

[design/fir_lp_ifs.sv]
// Valid/ready channel interfaces for the sample input and the filtered output.
`timescale 1ns / 1ps
`default_nettype none

interface fir_lp_in_if;
  logic                 valid;
  logic                 ready;
  fir_lp_pkg::sample_t  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface fir_lp_out_if;
  logic              valid;
  logic              ready;
  fir_lp_pkg::acc_t  filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

[design/fir_lp_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fir_lp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/fir_lp_mac.sv]
// Multiply-accumulate datapath: one tap product per cycle into the running sum.
`timescale 1ns / 1ps
`default_nettype none

module fir_lp_mac (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fir_lp_pkg::tap_ctl_t ctl,
  input  wire fir_lp_pkg::sample_t  rd_data,
  output fir_lp_pkg::acc_t          acc,
  output logic                      res_ready
);

  fir_lp_pkg::sample_t data_eff;
  fir_lp_pkg::coef_t   coef;
  fir_lp_pkg::prod_t   prod_nxt;
  fir_lp_pkg::prod_t   prod_r;
  fir_lp_pkg::acc_t    acc_nxt;
  fir_lp_pkg::acc_t    acc_r;
  logic                s1_vld_r;
  logic                s1_first_r;
  logic                s1_last_r;
  logic                res_nxt;
  logic                res_r;

  // An entry never written since reset reads as zero.
  assign data_eff = ctl.live ? rd_data : '0;
  assign coef     = fir_lp_pkg::COEF_Q[ctl.tap];
  assign prod_nxt = data_eff * coef;

  always_comb begin
    acc_nxt = acc_r;
    if (s1_vld_r) begin
      acc_nxt = s1_first_r ? fir_lp_pkg::acc_t'(prod_r)
                           : acc_r + fir_lp_pkg::acc_t'(prod_r);
    end
  end

  always_comb begin
    res_nxt = res_r;
    priority if (ctl.vld && ctl.first) begin
      res_nxt = 1'b0;
    end else if (s1_vld_r && s1_last_r) begin
      res_nxt = 1'b1;
    end else begin
      res_nxt = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      res_r    <= 1'b0;
    end else begin
      s1_vld_r <= ctl.vld;
      res_r    <= res_nxt;
    end
    s1_first_r <= ctl.first;
    s1_last_r  <= ctl.last;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
  end

  assign acc       = acc_r;
  assign res_ready = res_r;

endmodule

`default_nettype wire

[design/fir_lp_ctrl.sv]
// Sequencer: delay-line addressing, tap walk and both channel handshakes.
`timescale 1ns / 1ps
`default_nettype none

module fir_lp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  fir_lp_in_if.sink                 in_ch,
  fir_lp_out_if.source              out_ch,
  input  wire fir_lp_pkg::acc_t     mac_acc,
  input  wire logic                 mac_res_ready,
  output logic                      ram_wr_en,
  output fir_lp_pkg::slot_t         ram_wr_addr,
  output fir_lp_pkg::sample_t       ram_wr_data,
  output logic                      ram_rd_en,
  output fir_lp_pkg::slot_t         ram_rd_addr,
  output fir_lp_pkg::tap_ctl_t      ctl
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  localparam fir_lp_pkg::slot_t LAST_SLOT = fir_lp_pkg::SLOT_W'(fir_lp_pkg::TAPS - 1);

  state_t                   state_r, state_nxt;
  fir_lp_pkg::slot_t        wslot_r, wslot_nxt;
  fir_lp_pkg::slot_t        rslot_r, rslot_nxt;
  fir_lp_pkg::slot_t        tap_r, tap_nxt;
  logic [fir_lp_pkg::TAPS-1:0] written_r, written_nxt;
  fir_lp_pkg::tap_ctl_t     ctl_r, ctl_nxt;
  logic                     out_valid_r, out_valid_nxt;
  fir_lp_pkg::acc_t         out_filtered_r, out_filtered_nxt;
  logic                     in_fire;
  logic                     out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign ram_wr_en   = in_fire;
  assign ram_wr_addr = wslot_r;
  assign ram_wr_data = in_ch.sample;
  assign ram_rd_en   = (state_r == ST_RUN);
  assign ram_rd_addr = rslot_r;

  always_comb begin
    state_nxt        = state_r;
    wslot_nxt        = wslot_r;
    rslot_nxt        = rslot_r;
    tap_nxt          = tap_r;
    written_nxt      = written_r;
    out_valid_nxt    = out_valid_r;
    out_filtered_nxt = out_filtered_r;

    ctl_nxt.vld   = (state_r == ST_RUN);
    ctl_nxt.first = (tap_r == '0);
    ctl_nxt.last  = (tap_r == LAST_SLOT);
    ctl_nxt.live  = written_r[rslot_r];
    ctl_nxt.tap   = tap_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          written_nxt[wslot_r] = 1'b1;
          rslot_nxt = wslot_r;
          wslot_nxt = (wslot_r >= LAST_SLOT) ? '0 : wslot_r + 1'b1;
          tap_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        rslot_nxt = (rslot_r == '0) ? LAST_SLOT : rslot_r - 1'b1;
        tap_nxt   = tap_r + 1'b1;
        if (tap_r == LAST_SLOT) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_res_ready && out_free) begin
          out_valid_nxt    = 1'b1;
          out_filtered_nxt = mac_acc;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wslot_r     <= '0;
      rslot_r     <= '0;
      tap_r       <= '0;
      written_r   <= '0;
      ctl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wslot_r     <= wslot_nxt;
      rslot_r     <= rslot_nxt;
      tap_r       <= tap_nxt;
      written_r   <= written_nxt;
      ctl_r       <= ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_filtered_r <= out_filtered_nxt;
  end

  assign ctl             = ctl_r;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.filtered = out_filtered_r;

endmodule

`default_nettype wire

[design/fir_lowpass_49_tap.sv]
// An accepted sample is written to the delay line, then the run state walks the taps.
// Items are taken only when idle; the single multiply-accumulate unit sets the rate,
// taking one tap per cycle from the one read port of the delay-line RAM.
// A finished result waits in the output register while the next item is accepted.
// Reset (synchronous, active low) empties the output, sets the write slot to zero
// and marks every delay-line entry unwritten, so it reads as zero until written.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the 50-tap direct-form low-pass filter for one accelerometer axis.
//
// The delay line lives in a 50-entry synchronous RAM. Each accepted item is written
// into the current write slot; the sequencer then walks backwards from that slot,
// reading one entry per cycle, and the datapath multiplies it by the matching
// coefficient and accumulates. The read data is registered in the RAM, the product
// is registered, then the sum register is updated. One flip-flop per entry records
// whether it has been written since reset; an unwritten entry contributes zero,
// which stands in for a cleared line.
//
// The sum is kept at the output width and simply wraps, which gives exactly the low
// bits of the true sum; with these coefficients it never overflows anyway.
module fir_lowpass_49_tap (
  input  wire logic    clk,
  input  wire logic    rst_n,
  fir_lp_in_if.sink    in_chan,
  fir_lp_out_if.source out_chan
);

  logic                  ram_wr_en;
  fir_lp_pkg::slot_t     ram_wr_addr;
  fir_lp_pkg::sample_t   ram_wr_data;
  logic                  ram_rd_en;
  fir_lp_pkg::slot_t     ram_rd_addr;
  fir_lp_pkg::sample_t   ram_rd_data;
  fir_lp_pkg::tap_ctl_t  tap_ctl;
  fir_lp_pkg::acc_t      mac_acc;
  logic                  mac_res_ready;

  // Sequencer and both handshakes.
  fir_lp_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_chan),
    .out_ch        (out_chan),
    .mac_acc       (mac_acc),
    .mac_res_ready (mac_res_ready),
    .ram_wr_en     (ram_wr_en),
    .ram_wr_addr   (ram_wr_addr),
    .ram_wr_data   (ram_wr_data),
    .ram_rd_en     (ram_rd_en),
    .ram_rd_addr   (ram_rd_addr),
    .ctl           (tap_ctl)
  );

  // Circular delay line. Writes happen only in the idle cycle and reads only
  // afterwards, so the same entry is never written and read in one cycle.
  fir_lp_ram #(
    .WIDTH (fir_lp_pkg::SAMPLE_BITS),
    .DEPTH (fir_lp_pkg::TAPS)
  ) u_delay_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Multiply-accumulate over the taps.
  fir_lp_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (tap_ctl),
    .rd_data   (ram_rd_data),
    .acc       (mac_acc),
    .res_ready (mac_res_ready)
  );

endmodule

`default_nettype wire

[design/fir_lp_checker.sv]
// Port-level assertions for the low-pass filter and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

`include "fir_lowpass_49_tap_assert.svh"

module fir_lp_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire fir_lp_pkg::acc_t out_filtered
);

  `FIR_LP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result item dropped while stalled")
  `FIR_LP_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_filtered), "stalled result item changed")
  `FIR_LP_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "input taken while busy")
  `FIR_LP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result item present after reset")

endmodule

bind fir_lowpass_49_tap fir_lp_checker u_fir_lp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_filtered (out_chan.filtered)
);

`default_nettype wire

[verif/fir_lowpass_49_tap_checker.sv]
// Checker for the low-pass filter: predicts each filtered item and compares it with the output.
`timescale 1ns / 1ps

module fir_lowpass_49_tap_checker (
  input  logic  clk,
  input  logic  rst_n,
  fir_lp_in_if  in_mon,
  fir_lp_out_if out_mon,
  output int    fail_count,
  output int    pending_count
);
  import fir_lp_pkg::*;

  // Low-pass taps in units of 1e-4, newest sample first; taps past the list weigh zero.
  localparam int WEIGHT_LIST_LEN = 49;
  localparam int TAP_E4 [WEIGHT_LIST_LEN] = '{
      46,    74,   -24,   -71,    33,     1,   -94,    40,    44,
    -133,    30,   114,  -179,   -11,   223,  -225,  -109,   396,
    -263,  -338,   752,  -289, -1204,  2879,  6369,  2879, -1204,
    -289,   752,  -338,  -263,   396,  -109,  -225,   223,   -11,
    -179,   114,    30,  -133,    44,    40,   -94,     1,    33,
     -71,   -24,    74,    46
  };

  longint      tap_weight [TAPS];
  sample_t     sample_hist [TAPS];
  int unsigned next_slot;
  acc_t        filtered_q [$];
  acc_t        want;
  int          mismatches = 0;

  // Scales a weight to the coefficient grid, rounding halves away from zero.
  function automatic longint weight_from_e4(int c);
    longint mag;
    longint q;
    mag = (c < 0) ? -longint'(c) : longint'(c);
    q = (mag * (longint'(1) << COEF_FRAC_BITS) + 5000) / 10000;
    return (c < 0) ? -q : q;
  endfunction

  // Exact sum over all taps, walking back from the newest sample; kept to the output width.
  function automatic acc_t filter_sum(int unsigned newest);
    longint      acc;
    int unsigned pos;
    acc = 0;
    pos = newest;
    for (int i = 0; i < TAPS; i++) begin
      acc += longint'(sample_hist[pos]) * tap_weight[i];
      pos = (pos == 0) ? TAPS - 1 : pos - 1;
    end
    return acc_t'(acc);
  endfunction

  initial begin
    foreach (tap_weight[i]) begin
      tap_weight[i] = (i < WEIGHT_LIST_LEN) ? weight_from_e4(TAP_E4[i]) : 0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (sample_hist[i]) sample_hist[i] = '0;
      next_slot = 0;
      filtered_q.delete();
    end else begin
      // The result side is looked at first, so an item arriving in the same cycle
      // cannot stand in for a missing expectation.
      if (out_mon.valid && out_mon.ready) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected filtered item, got %0d", $time, out_mon.filtered);
          mismatches++;
        end else begin
          want = filtered_q.pop_front();
          if (want !== out_mon.filtered) begin
            $display("%0t: filtered mismatch, expected %0d, got %0d",
                     $time, want, out_mon.filtered);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        sample_hist[next_slot] = in_mon.sample;
        filtered_q.push_back(filter_sum(next_slot));
        next_slot = (next_slot + 1 >= TAPS) ? 0 : next_slot + 1;
      end
    end
    fail_count    <= mismatches;
    pending_count <= filtered_q.size();
  end

endmodule

[verif/tb_fir_lowpass_49_tap.sv]
// Top of the low-pass filter testbench: clock, reset, sample stimulus, result stalls and verdict.
`timescale 1ns / 1ps

// The filter is fed first with a short list of hand-picked samples and then with
// bursts of random shape: plain random samples, extremes only, small values,
// steps, impulses followed by a full line of zeros, and runs that match the signs
// of the coefficients so that the sum reaches its largest and smallest values.
// Before each burst both sides choose a new idling profile, so gaps and stalls
// land on every phase of the filter's work, with some bursts free of idling.
// The checker beside the filter predicts every result and counts failures; this
// module only drives the channels and gives the verdict.
module tb_fir_lowpass_49_tap;
  import fir_lp_pkg::*;

  localparam int RANDOM_TARGET = 1220;
  localparam int DIRECTED [20] = '{
    0, 4095, -4096, -1, 1, 4095, 4095, 4095, -4096, -4096,
    -4096, 2048, -2048, 1365, -1366, 0, 4095, 0, 0, -1
  };
  localparam sample_t EXTREMES [4] = '{
    sample_t'(4095), sample_t'(-4096), sample_t'(0), sample_t'(-1)
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fir_lp_in_if  in_chan ();
  fir_lp_out_if out_chan ();

  int fail_count;
  int pending_count;
  int max_send_gap   = 0;
  int max_take_stall = 0;
  int sent           = 0;

  fir_lowpass_49_tap u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  fir_lowpass_49_tap_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk = ~clk;

  // Hard stop well beyond the slowest correct run.
  initial begin
    #6_000_000;
    $display("tb_fir_lowpass_49_tap NOT OK");
    $finish;
  end

  // Offers one sample after a random gap and holds it until the filter takes it.
  task automatic send_sample(input sample_t s);
    int gap;
    gap = $urandom_range(max_send_gap, 0);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.sample <= s;
    in_chan.valid  <= 1'b1;
    do @(posedge clk); while (!(in_chan.valid && in_chan.ready));
    sent++;
  endtask

  // Stops offering and waits until every predicted item has come out. The count from
  // the checker is registered, so it is first looked at after the next edge.
  task automatic drain_filter();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Either side may idle freely, not at all, or one of the two alone.
  task automatic pick_idling();
    case ($urandom_range(3, 0))
      0: begin
        max_send_gap   = 0;
        max_take_stall = 0;
      end
      1: begin
        max_send_gap   = 15;
        max_take_stall = 15;
      end
      2: begin
        max_send_gap   = 15;
        max_take_stall = 0;
      end
      default: begin
        max_send_gap   = 0;
        max_take_stall = 15;
      end
    endcase
  endtask

  // Result side: before each item it stalls for a random number of cycles, then
  // holds ready high until an item is taken.
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = $urandom_range(max_take_stall, 0);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid && out_chan.ready));
    end
  end

  initial begin
    int      len;
    int      idx;
    int      c;
    bit      flip;
    sample_t hold;

    in_chan.valid  = 1'b0;
    in_chan.sample = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Hand-picked samples: both extremes, zero, plus and minus one, repeated extremes
    // that push the sum hard, and alternating bit patterns.
    pick_idling();
    foreach (DIRECTED[i]) send_sample(sample_t'(DIRECTED[i]));
    // Let everything come out before the random part begins.
    drain_filter();

    while (sent < RANDOM_TARGET) begin
      pick_idling();
      len = $urandom_range(60, 10);
      case ($urandom_range(9, 0))
        4: begin
          repeat (len) send_sample(EXTREMES[$urandom_range(3, 0)]);
        end
        5: begin
          repeat (len) send_sample(sample_t'(int'($urandom_range(16, 0)) - 8));
        end
        6: begin
          // The sample that ends up under each tap carries the sign of its coefficient,
          // or the opposite sign, so the last sum of the run is the largest or smallest
          // that the filter can give. The tap beyond the list weighs zero.
          flip = $urandom_range(1, 0);
          for (int k = 0; k < TAPS; k++) begin
            idx = TAPS - 1 - k;
            c = (idx < COEF_TABLE_LEN) ? COEF_E4[idx] : 0;
            send_sample(((c < 0) ^ flip) ? sample_t'(-4096) : sample_t'(4095));
          end
        end
        7: begin
          // An impulse followed by a full line of zeros shows every coefficient alone,
          // the zero tap at the far end included.
          send_sample(EXTREMES[$urandom_range(1, 0)]);
          repeat (TAPS) send_sample('0);
        end
        8: begin
          hold = sample_t'($urandom);
          repeat (len) send_sample(hold);
        end
        9: begin
          drain_filter();
        end
        default: begin
          repeat (len) send_sample(sample_t'($urandom));
        end
      endcase
    end

    // Wait for the last results, then a little longer in case anything stray follows.
    drain_filter();
    repeat (60) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_fir_lowpass_49_tap OK");
    end else begin
      $display("tb_fir_lowpass_49_tap NOT OK");
    end
    $finish;
  end

endmodule
